[sv/imq_pkg.sv]
// Package for the indexed min-heap queue: defaults, codes and item types.
package imq_pkg;

  localparam int HEAP_DEPTH_DEF   = 256;
  localparam int KEY_BITS_DEF     = 64;
  localparam int HANDLE_COUNT_DEF = 256;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_REKEY  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_ABSENT      = 3'd3;
  localparam logic [2:0] ST_DUPLICATE   = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [7:0]  handle;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] removed_key;
    logic [7:0]  removed_handle;
    logic [8:0]  entry_count;
    logic        top_valid;
    logic [63:0] top_key;
    logic [7:0]  top_handle;
  } rsp_t;

endpackage

[sv/indexed_min_heap_queue_top.sv]
// Result time is set by one slot-memory access per step of the sift path (states DN_L, DN_LW
// and, where a right child exists, DN_RW per level going down, RU and RU_W going up).
// One item in flight; the next is taken in the idle state after the result is loaded,
// and a finished result may wait while the next item is taken.
// Reset: synchronous; after it a clearing pass marks every handle
// absent in the position memory, and no item is accepted until it ends.
// Heap slots are undefined until written; entry count zero; tracking enabled.
module indexed_min_heap_queue_top #(
  parameter int HEAP_DEPTH   = imq_pkg::HEAP_DEPTH_DEF,
  parameter int KEY_BITS     = imq_pkg::KEY_BITS_DEF,
  parameter int HANDLE_COUNT = imq_pkg::HANDLE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  imq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output imq_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic          cfg_data
);

  localparam int SB = $clog2(HEAP_DEPTH);
  localparam int CB = $clog2(HEAP_DEPTH + 1);
  localparam int HB = $clog2(HANDLE_COUNT);

  typedef enum logic [11:0] {
    S_CLR     = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_LOOKUP  = 12'b000000000100,
    S_RM_RD   = 12'b000000001000,
    S_CK_RD   = 12'b000000010000,
    S_DN_L    = 12'b000000100000,
    S_DN_LW   = 12'b000001000000,
    S_DN_RW   = 12'b000010000000,
    S_LAST_RD = 12'b000100000000,
    S_RU      = 12'b001000000000,
    S_RU_W    = 12'b010000000000,
    S_FIN     = 12'b100000000000
  } state_t;

  typedef struct packed {
    logic          valid;
    logic [SB-1:0] slot;
  } pos_t;

  // memories
  logic [KEY_BITS-1:0] slot_key_mem [HEAP_DEPTH];
  logic [7:0]          slot_h_mem   [HEAP_DEPTH];
  pos_t                pos_mem      [HANDLE_COUNT];

  logic                slot_we;
  logic [SB-1:0]       slot_wa, slot_ra;
  logic [KEY_BITS-1:0] slot_wk, rd_k;
  logic [7:0]          slot_wh, rd_h;
  logic                pos_we;
  logic [HB-1:0]       pos_wa, pos_ra;
  pos_t                pos_wd, pos_rd;

  // control registers
  state_t              state, state_next;
  logic [HB-1:0]       clr_idx;
  logic [1:0]          cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [7:0]          h_r;
  logic [SB-1:0]       hole, hole_next;
  logic [CB-1:0]       total, total_next;
  logic [KEY_BITS-1:0] ek, ek_next, lk, lk_next, rm_k, rm_k_next;
  logic [7:0]          eh, eh_next, lh, lh_next, rm_h, rm_h_next;
  logic [2:0]          status_r, status_next;
  logic                up_strict, up_strict_next;
  logic                mode_chg, mode_chg_next;
  logic                track;
  logic [KEY_BITS-1:0] top_k;
  logic [7:0]          top_h;

  logic [SB:0]         c_full;
  logic [SB-1:0]       c_idx, last, parent;
  logic                c_past_last, c_is_last, h_in_range;
  logic                pick_right;
  logic [KEY_BITS-1:0] ck;
  logic [7:0]          ch;
  logic [SB-1:0]       ci;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_key_mem[slot_wa] <= slot_wk;
      slot_h_mem[slot_wa]   <= slot_wh;
    end
    rd_k <= slot_key_mem[slot_ra];
    rd_h <= slot_h_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd <= pos_mem[pos_ra];
  end

  assign last        = SB'(total - CB'(1));
  assign c_full      = {hole, 1'b1};
  assign c_idx       = c_full[SB-1:0];
  assign c_past_last = (total == '0) || (c_full > (SB+1)'(last));
  assign c_is_last   = c_full == (SB+1)'(last);
  assign parent      = SB'((hole - SB'(1)) >> 1);
  assign h_in_range  = 32'(h_r) < HANDLE_COUNT;
  assign req_ready   = state == S_IDLE;

  // child chosen on the way down
  assign pick_right = (state == S_DN_RW) && (rd_k < lk);
  assign ck = (state == S_DN_LW) ? rd_k : (pick_right ? rd_k : lk);
  assign ch = (state == S_DN_LW) ? rd_h : (pick_right ? rd_h : lh);
  assign ci = pick_right ? c_idx + SB'(1) : c_idx;

  always_comb begin
    state_next     = state;
    hole_next      = hole;
    total_next     = total;
    ek_next        = ek;
    eh_next        = eh;
    lk_next        = lk;
    lh_next        = lh;
    rm_k_next      = rm_k;
    rm_h_next      = rm_h;
    status_next    = status_r;
    up_strict_next = up_strict;
    mode_chg_next  = mode_chg;
    slot_we        = 1'b0;
    slot_wa        = hole;
    slot_wk        = ek;
    slot_wh        = eh;
    slot_ra        = hole;
    pos_we         = 1'b0;
    pos_wa         = clr_idx;
    pos_wd         = '0;
    pos_ra         = HB'(req.handle);

    unique case (state)
      S_CLR: begin
        pos_we = 1'b1;
        if (clr_idx == HB'(HANDLE_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          status_next = imq_pkg::ST_OK;
          rm_k_next   = '0;
          rm_h_next   = '0;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_next = S_FIN;
        priority case (cmd_r)
          imq_pkg::CMD_PUSH: begin
            if (!h_in_range) status_next = imq_pkg::ST_UNSUPPORTED;
            else if (pos_rd.valid) status_next = imq_pkg::ST_DUPLICATE;
            else if (32'(total) >= HEAP_DEPTH) status_next = imq_pkg::ST_FULL;
            else begin
              hole_next      = SB'(total);
              ek_next        = key_r;
              eh_next        = h_r;
              total_next     = total + CB'(1);
              up_strict_next = 1'b0;
              state_next     = S_RU;
            end
          end
          imq_pkg::CMD_POP: begin
            if (total == '0) status_next = imq_pkg::ST_EMPTY;
            else begin
              rm_k_next     = top_k;
              rm_h_next     = top_h;
              pos_we        = 1'b1;
              pos_wa        = HB'(top_h);
              hole_next     = '0;
              mode_chg_next = 1'b0;
              state_next    = S_DN_L;
            end
          end
          default: begin
            if (!track) status_next = imq_pkg::ST_UNSUPPORTED;
            else if (!h_in_range || !pos_rd.valid) status_next = imq_pkg::ST_ABSENT;
            else begin
              slot_ra    = pos_rd.slot;
              hole_next  = pos_rd.slot;
              state_next = (cmd_r == imq_pkg::CMD_REMOVE) ? S_RM_RD : S_CK_RD;
            end
          end
        endcase
      end
      S_RM_RD: begin
        rm_k_next     = rd_k;
        rm_h_next     = rd_h;
        pos_we        = 1'b1;
        pos_wa        = HB'(rd_h);
        mode_chg_next = 1'b0;
        state_next    = S_DN_L;
      end
      S_CK_RD: begin
        ek_next = key_r;
        eh_next = rd_h;
        if (key_r < rd_k) begin
          up_strict_next = 1'b1;
          state_next     = S_RU;
        end else begin
          mode_chg_next = 1'b1;
          state_next    = S_DN_L;
        end
      end
      S_DN_L: begin
        if (!c_past_last) begin
          slot_ra    = c_idx;
          state_next = S_DN_LW;
        end else if (mode_chg) begin
          slot_we    = 1'b1;
          state_next = S_FIN;
        end else begin
          total_next = total - CB'(1);
          if (hole != last) begin
            slot_ra    = last;
            state_next = S_LAST_RD;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_DN_LW, S_DN_RW: begin
        lk_next = (state == S_DN_LW) ? rd_k : lk;
        lh_next = (state == S_DN_LW) ? rd_h : lh;
        if (state == S_DN_LW && !c_is_last) begin
          slot_ra    = c_idx + SB'(1);
          state_next = S_DN_RW;
        end else if (mode_chg && !(ck < ek)) begin
          slot_we    = 1'b1;
          state_next = S_FIN;
        end else begin
          slot_we    = 1'b1;
          slot_wk    = ck;
          slot_wh    = ch;
          hole_next  = ci;
          state_next = S_DN_L;
        end
      end
      S_LAST_RD: begin
        ek_next        = rd_k;
        eh_next        = rd_h;
        up_strict_next = 1'b0;
        state_next     = S_RU;
      end
      S_RU: begin
        if (hole == '0) begin
          slot_we    = 1'b1;
          state_next = S_FIN;
        end else begin
          slot_ra    = parent;
          state_next = S_RU_W;
        end
      end
      S_RU_W: begin
        if (up_strict ? !(ek < rd_k) : (rd_k < ek)) begin
          slot_we    = 1'b1;
          state_next = S_FIN;
        end else begin
          slot_we    = 1'b1;
          slot_wk    = rd_k;
          slot_wh    = rd_h;
          hole_next  = parent;
          state_next = S_RU;
        end
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    // every slot write moves its handle's position along with it
    if (slot_we) begin
      pos_we = 1'b1;
      pos_wa = HB'(slot_wh);
      pos_wd = '{valid: 1'b1, slot: slot_wa};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      total     <= '0;
      track     <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      total   <= total_next;
      if (state == S_CLR) clr_idx <= clr_idx + HB'(1);
      if (cfg_we) track <= cfg_data;
      if (state == S_FIN && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    hole      <= hole_next;
    ek        <= ek_next;
    eh        <= eh_next;
    lk        <= lk_next;
    lh        <= lh_next;
    rm_k      <= rm_k_next;
    rm_h      <= rm_h_next;
    status_r  <= status_next;
    up_strict <= up_strict_next;
    mode_chg  <= mode_chg_next;
    if (state == S_IDLE && req_valid) begin
      cmd_r <= req.cmd;
      key_r <= KEY_BITS'(req.key);
      h_r   <= req.handle;
    end
    if (slot_we && slot_wa == '0) begin
      top_k <= slot_wk;
      top_h <= slot_wh;
    end
    if (state == S_FIN && (!rsp_valid || rsp_ready)) begin
      rsp.status         <= status_r;
      rsp.removed_key    <= 64'(rm_k);
      rsp.removed_handle <= rm_h;
      rsp.entry_count    <= 9'(total);
      rsp.top_valid      <= total != '0;
      rsp.top_key        <= (total != '0) ? 64'(top_k) : 64'd0;
      rsp.top_handle     <= (total != '0) ? top_h : 8'd0;
    end
  end

endmodule
